FILE: rtl/bmon_pkg.sv
// Shared types, constants and defaults for the battery ADC trimmed-mean monitor.
package bmon_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLES_PER_READING_DEF = 9;
  localparam int ADC_BITS_DEF            = 12;

  // Fixed field widths.
  localparam int MV_W   = 14;
  localparam int PCT_W  = 7;
  localparam int CFG_W  = 14;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FULL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EMPTY = 2'd1;
  localparam logic [CFG_W-1:0]     FULL_MV_RESET  = 14'd4160;
  localparam logic [CFG_W-1:0]     EMPTY_MV_RESET = 14'd2500;

  // Millivolt scale: 3.3 V full scale times a divide-by-three network.
  localparam logic [MV_W-1:0] MV_SCALE = 14'd9900;

  // Percentage arithmetic: numerator is (mv - empty) * 100, below 2^20.
  localparam int PCT_NUM_W = 20;
  localparam int DIV_STEPS = PCT_NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CODE,
    ST_MUL,
    ST_PCT,
    ST_DIV,
    ST_OUT
  } bmon_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic accumulate;
    logic make_code;
    logic make_mv;
    logic pct_init;
    logic div_step;
    logic load_out;
  } bmon_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } bmon_status_t;

endpackage

FILE: rtl/bmon_datapath.sv
// Datapath: sample quotients, running extremes, scaling, percent divider, output register.
module bmon_datapath #(
  parameter int SAMPLES_PER_READING = bmon_pkg::SAMPLES_PER_READING_DEF,
  parameter int ADC_BITS            = bmon_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmon_pkg::bmon_cmd_t                 cmd,
  output bmon_pkg::bmon_status_t              status,
  input  logic [ADC_BITS-1:0]                 in_sample,
  input  logic                                cfg_write,
  input  logic [bmon_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmon_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [ADC_BITS-1:0]                 out_code,
  output logic [bmon_pkg::MV_W-1:0]           out_mv,
  output logic [bmon_pkg::PCT_W-1:0]          out_pct
);
  import bmon_pkg::*;

  localparam int TRIM_DIV    = SAMPLES_PER_READING - 2;
  localparam int QW          = ADC_BITS;
  localparam int SUM_W       = ADC_BITS + 2;
  // Reciprocal for an exact floor divide by TRIM_DIV over the sample range.
  localparam int RECIP_SHIFT = ADC_BITS + 4;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + TRIM_DIV - 1) / TRIM_DIV);
  localparam int PROD_W      = ADC_BITS + RECIP_W;
  localparam int MVP_W       = ADC_BITS + MV_W;

  logic [CFG_W-1:0]     full_r, empty_r;
  logic [ADC_BITS-1:0]  sample_r;
  logic [SUM_W-1:0]     sum_r;
  logic [QW-1:0]        qmin_r, qmax_r;
  logic [ADC_BITS-1:0]  code_r;
  logic [MV_W-1:0]      mv_r;
  logic                 below_r, nospan_r;
  logic [CFG_W-1:0]     den_r;
  logic [CFG_W-1:0]     rem_r;
  logic [PCT_NUM_W-1:0] quo_r;
  logic                 out_valid_r;
  logic [ADC_BITS-1:0]  out_code_r;
  logic [MV_W-1:0]      out_mv_r;
  logic [PCT_W-1:0]     out_pct_r;

  logic [PROD_W-1:0]    prod;
  logic [QW-1:0]        quot;
  logic [SUM_W-1:0]     code_full;
  logic [MVP_W-1:0]     mv_prod;
  logic [MV_W-1:0]      mv_diff;
  logic [CFG_W:0]       rem_sh;
  logic                 rem_ge;
  logic [PCT_W-1:0]     pct_val;

  // Floor divide of the current sample by the trim divisor.
  always_comb begin
    prod = PROD_W'(sample_r) * PROD_W'(RECIP);
    quot = QW'(prod >> RECIP_SHIFT);
  end

  assign code_full = sum_r - SUM_W'(qmin_r) - SUM_W'(qmax_r);
  assign mv_prod   = MVP_W'(code_r) * MVP_W'(MV_SCALE);
  assign mv_diff   = mv_r - empty_r;

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_r, quo_r[PCT_NUM_W-1]};
    rem_ge = rem_sh >= {1'b0, den_r};
  end

  // Saturated percentage from the divider result and the special cases.
  always_comb begin
    priority if (below_r) begin
      pct_val = '0;
    end else if (nospan_r) begin
      pct_val = PCT_MAX;
    end else if (quo_r > PCT_NUM_W'(PCT_MAX)) begin
      pct_val = PCT_MAX;
    end else begin
      pct_val = quo_r[PCT_W-1:0];
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= FULL_MV_RESET;
      empty_r <= EMPTY_MV_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IDX_FULL:  full_r  <= cfg_data;
        CFG_IDX_EMPTY: empty_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Group accumulation state, cleared when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      qmin_r <= '1;
      qmax_r <= '0;
    end else if (cmd.load_out) begin
      sum_r  <= '0;
      qmin_r <= '1;
      qmax_r <= '0;
    end else if (cmd.accumulate) begin
      sum_r <= sum_r + SUM_W'(quot);
      if (quot < qmin_r) begin
        qmin_r <= quot;
      end
      if (quot > qmax_r) begin
        qmax_r <= quot;
      end
    end
  end

  // Sample capture, code, millivolts and the percent divider.
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_r <= in_sample;
    end
    if (cmd.make_code) begin
      code_r <= code_full[ADC_BITS-1:0];
    end
    if (cmd.make_mv) begin
      mv_r <= mv_prod[MVP_W-1:ADC_BITS];
    end
    if (cmd.pct_init) begin
      below_r  <= mv_r < empty_r;
      nospan_r <= full_r <= empty_r;
      den_r    <= full_r - empty_r;
      rem_r    <= '0;
      quo_r    <= PCT_NUM_W'(mv_diff) * PCT_NUM_W'(PCT_MAX);
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= CFG_W'(rem_sh - {1'b0, den_r});
        quo_r <= {quo_r[PCT_NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CFG_W-1:0];
        quo_r <= {quo_r[PCT_NUM_W-2:0], 1'b0};
      end
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_code_r <= code_r;
      out_mv_r   <= mv_r;
      out_pct_r  <= pct_val;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_code        = out_code_r;
  assign out_mv          = out_mv_r;
  assign out_pct         = out_pct_r;

endmodule

FILE: rtl/bmon_ctrl.sv
// Controller: sequences sample accumulation, scaling, division and result hand-off.
module bmon_ctrl #(
  parameter int SAMPLES_PER_READING = bmon_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  bmon_pkg::bmon_status_t status,
  output bmon_pkg::bmon_cmd_t    cmd
);
  import bmon_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_READING);
  localparam logic [CNT_W:0] LAST_COUNT = (CNT_W + 1)'(SAMPLES_PER_READING);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  bmon_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CNT_W:0]       count_inc;

  assign count_inc = {1'b0, count_r} + 1'b1;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_sample = 1'b1;
          state_nxt       = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        if (count_inc == LAST_COUNT) begin
          count_nxt = '0;
          state_nxt = ST_CODE;
        end else begin
          count_nxt = count_inc[CNT_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      ST_CODE: begin
        cmd.make_code = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.make_mv = 1'b1;
        state_nxt   = ST_PCT;
      end
      ST_PCT: begin
        cmd.pct_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/battery_adc_trimmed_mean_monitor_core.sv
// Top level of the battery ADC trimmed-mean monitor.
//
// Samples arrive on the in_ stream, one ADC reading per transfer. After every
// SAMPLES_PER_READING samples the block drops one smallest and one largest
// sample, sums the floored sevenths (divisor SAMPLES_PER_READING - 2) of the
// rest and sends one result transfer on the out_ stream: the filtered code,
// the voltage in millivolts and a charge percentage between the empty and
// full thresholds written through the cfg_ port (always ready).
// Each sample is taken in a transfer and then an accumulate state. After the last
// sample of a group come code, millivolt multiply, setup, then 20 steps of
// the restoring divider that forms the percentage, and the load into the output
// register, which waits for a free slot. That divider sets the group latency.
// The output register holds a result until the receiver takes it; the next
// group is collected meanwhile and only its final load waits for the slot.
// Synchronous reset restores the default thresholds, empties the group and
// drops any pending result.
module battery_adc_trimmed_mean_monitor_core #(
  parameter int SAMPLES_PER_READING = bmon_pkg::SAMPLES_PER_READING_DEF,
  parameter int ADC_BITS            = bmon_pkg::ADC_BITS_DEF,
  parameter int IN_W  = ((ADC_BITS + 7) / 8) * 8,
  parameter int OUT_W = ((ADC_BITS + bmon_pkg::MV_W + bmon_pkg::PCT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Sample stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // adc_sample
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // filtered_code, millivolts, percent
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmon_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmon_pkg::CFG_W-1:0]     cfg_data
);
  import bmon_pkg::*;

  localparam int PAD_W = OUT_W - ADC_BITS - MV_W - PCT_W;

  bmon_cmd_t           cmd;
  bmon_status_t        status;
  logic [ADC_BITS-1:0] out_code;
  logic [MV_W-1:0]     out_mv;
  logic [PCT_W-1:0]    out_pct;

  assign cfg_ready = 1'b1;

  bmon_ctrl #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bmon_datapath #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING),
    .ADC_BITS           (ADC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (in_tdata[ADC_BITS-1:0]),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_code   (out_code),
    .out_mv     (out_mv),
    .out_pct    (out_pct)
  );

  // Pack the result fields from the lowest bit up.
  assign out_tdata = {{PAD_W{1'b0}}, out_pct, out_mv, out_code};

  // A pending result never claims more than full charge.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_pct <= PCT_MAX))
    else $error("percent above 100");

  // Millivolts stay below the full-scale value.
  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_mv < MV_SCALE))
    else $error("millivolts out of range");

  // After a sample transfer the block is busy accumulating in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sample accepted while accumulating");

  // A new result is loaded only into a free output slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result overwritten before transfer");

endmodule

FILE: tb/battery_adc_trimmed_mean_monitor_core_tb.sv
// Self-checking testbench for the battery ADC trimmed-mean monitor core.
module battery_adc_trimmed_mean_monitor_core_tb;
  import bmon_pkg::*;

  localparam int GROUP_LEN       = 9;
  localparam int ADC_BITS        = 12;
  localparam int TRIM_DIV        = GROUP_LEN - 2;
  localparam int IN_W            = 16;
  localparam int OUT_W           = 40;
  localparam int SAMPLE_MAX      = 4095;
  localparam int SETTLE_CYCLES   = 48;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 85;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam logic [CFG_W-1:0]     CFG_MAX         = 14'h3FFF;

  typedef struct packed {
    logic [11:0]      code;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } reading_t;

  typedef struct packed {
    logic [11:0] sample;
    logic        typed;
    reading_t    want;
  } stim_row_t;

  localparam reading_t NO_READING   = '0;
  localparam reading_t FULL_READING = '{12'd4095, 14'd9897, PCT_MAX};
  localparam reading_t ZERO_READING = '{12'd0, 14'd0, 7'd0};

  // Directed stimulus: a group at full scale (above full), a group of zeros with one
  // full-scale sample (below empty, equal minimums), then a partial group of mixed values.
  stim_row_t directed_rows [25] = '{
    '{12'd4095, 1'b0, NO_READING}, '{12'd4095, 1'b0, NO_READING},
    '{12'd4095, 1'b0, NO_READING}, '{12'd4095, 1'b0, NO_READING},
    '{12'd4095, 1'b0, NO_READING}, '{12'd4095, 1'b0, NO_READING},
    '{12'd4095, 1'b0, NO_READING}, '{12'd4095, 1'b0, NO_READING},
    '{12'd4095, 1'b1, FULL_READING},
    '{12'd4095, 1'b0, NO_READING}, '{12'd0, 1'b0, NO_READING},
    '{12'd0, 1'b0, NO_READING},    '{12'd0, 1'b0, NO_READING},
    '{12'd0, 1'b0, NO_READING},    '{12'd0, 1'b0, NO_READING},
    '{12'd0, 1'b0, NO_READING},    '{12'd0, 1'b0, NO_READING},
    '{12'd0, 1'b1, ZERO_READING},
    '{12'd2047, 1'b0, NO_READING}, '{12'd2048, 1'b0, NO_READING},
    '{12'd1, 1'b0, NO_READING},    '{12'd4094, 1'b0, NO_READING},
    '{12'd3500, 1'b0, NO_READING}, '{12'd3500, 1'b0, NO_READING},
    '{12'd1234, 1'b0, NO_READING}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor state: thresholds and the group being collected.
  logic [CFG_W-1:0] full_mv  = FULL_MV_RESET;
  logic [CFG_W-1:0] empty_mv = EMPTY_MV_RESET;
  int unsigned      grp_count = 0;
  logic [11:0]      grp_min   = '1;
  logic [11:0]      grp_max   = '0;
  logic [12:0]      grp_qsum  = '0;

  reading_t pending_readings [$];

  bit gaps_enabled  = 1'b1;
  bit hold_request  = 1'b0;
  int fail_count    = 0;
  int samples_sent  = 0;
  int readings_seen = 0;
  int writes_done   = 0;
  int settings_done = 0;
  int holds_done    = 0;
  int cycle_count   = 0;

  battery_adc_trimmed_mean_monitor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Charge level between the thresholds, saturated to 0..100.
  function automatic logic [PCT_W-1:0] charge_percent(input logic [MV_W-1:0] mv);
    int unsigned q;
    if (mv < empty_mv) return '0;
    if (full_mv <= empty_mv) return PCT_MAX;
    q = ((32'(mv) - 32'(empty_mv)) * 100) / (32'(full_mv) - 32'(empty_mv));
    return (q > 100) ? PCT_MAX : PCT_W'(q);
  endfunction

  // Adds one sample to the group; on the last sample it forms the reading and clears.
  function automatic bit fold_sample(input logic [11:0] s, output reading_t r);
    logic [31:0] code_full;
    r = '0;
    grp_qsum = grp_qsum + 13'(s / TRIM_DIV);
    if (s < grp_min) grp_min = s;
    if (s > grp_max) grp_max = s;
    grp_count++;
    if (grp_count < GROUP_LEN) return 1'b0;
    code_full = 32'(grp_qsum) - 32'(grp_min / TRIM_DIV) - 32'(grp_max / TRIM_DIV);
    r.code = code_full[11:0];
    r.mv   = MV_W'((32'(r.code) * 32'(MV_SCALE)) >> ADC_BITS);
    r.pct  = charge_percent(r.mv);
    grp_count = 0;
    grp_min   = '1;
    grp_max   = '0;
    grp_qsum  = '0;
    return 1'b1;
  endfunction

  function automatic logic [11:0] clamp_code(input int v);
    if (v < 0) return 12'd0;
    if (v > SAMPLE_MAX) return 12'(SAMPLE_MAX);
    return 12'(v);
  endfunction

  // One sample transfer after a random gap; in_tvalid stays high for back-to-back items.
  task automatic send_sample(input logic [11:0] s, input bit typed, input reading_t want);
    int       gap;
    reading_t r;
    gap = gaps_enabled ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, s};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    if (fold_sample(s, r)) pending_readings.push_back(typed ? want : r);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_FULL:  full_mv  = value;
      CFG_IDX_EMPTY: empty_mv = value;
      default: ;
    endcase
    writes_done++;
  endtask

  // Writes both thresholds, optionally followed by writes to unmapped indexes.
  task automatic configure(input logic [CFG_W-1:0] full, input logic [CFG_W-1:0] empty,
                           input bit with_spare);
    write_register(CFG_IDX_FULL, full);
    write_register(CFG_IDX_EMPTY, empty);
    if (with_spare) begin
      write_register(CFG_IDX_SPARE_A, CFG_MAX);
      write_register(CFG_IDX_SPARE_B, '0);
    end
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Waits for every expected reading, then lets a partial group's work finish.
  task automatic settle();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result receiver: random stalls, one long hold on request, and the field checks.
  initial begin : result_sink
    int       stall;
    reading_t want;
    reading_t got;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end else begin
        stall = gaps_enabled ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready === 1'b1));
      got.code = out_tdata[11:0];
      got.mv   = out_tdata[25:12];
      got.pct  = out_tdata[32:26];
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading pending: code %0d", got.code);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("filtered_code", want.code, got.code);
        check_field("millivolts", want.mv, got.mv);
        check_field("percent", want.pct, got.pct);
        check_field("padding", 0, out_tdata[OUT_W-1:33]);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [11:0] center;
    int          v;
    int unsigned empty_cfg;
    int unsigned full_cfg;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IDX_FULL;
    cfg_data  <= '0;
    center    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset thresholds.
    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
    in_tvalid <= 1'b0;

    // Random phases, each under its own threshold setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: configure(FULL_MV_RESET, EMPTY_MV_RESET, 1'b1);
        1: configure(CFG_MAX, '0, 1'b0);
        2: configure(14'd3000, 14'd3000, 1'b0);
        3: configure('0, CFG_MAX, 1'b0);
        4: configure('0, '0, 1'b0);
        5: begin
          // Span of only a few millivolts.
          empty_cfg = $urandom_range(0, 9000);
          full_cfg  = empty_cfg + $urandom_range(1, 4);
          configure(CFG_W'(full_cfg), CFG_W'(empty_cfg), 1'b0);
        end
        default: begin
          empty_cfg = $urandom_range(0, 8000);
          full_cfg  = empty_cfg + $urandom_range(100, 3000);
          configure(CFG_W'(full_cfg), CFG_W'(empty_cfg), 1'b0);
        end
      endcase
      gaps_enabled = (p != 3);
      hold_request = (p == 1);

      // Groups cluster around a center, half of them near the empty threshold.
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % GROUP_LEN == 0) begin
          if ($urandom_range(0, 1))
            center = $urandom_range(0, SAMPLE_MAX);
          else
            center = clamp_code(int'(empty_mv) * 4096 / int'(MV_SCALE)
                                + int'($urandom_range(0, 800)) - 100);
        end
        case ($urandom_range(0, 9))
          0, 1:    v = $urandom_range(0, SAMPLE_MAX);
          2:       v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          default: v = int'(center) + int'($urandom_range(0, 127)) - 64;
        endcase
        send_sample(clamp_code(v), 1'b0, NO_READING);
      end
      in_tvalid <= 1'b0;
    end

    settle();
    $display("Covered %0d samples and %0d readings under %0d threshold settings.",
             samples_sent, readings_seen, settings_done);
    $display("Register writes: %0d, long receiver holds: %0d, failures: %0d.",
             writes_done, holds_done, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bmon_pkg.sv
rtl/bmon_datapath.sv
rtl/bmon_ctrl.sv
rtl/battery_adc_trimmed_mean_monitor_core.sv
tb/battery_adc_trimmed_mean_monitor_core_tb.sv
